>>> src/sync_length_checksum_frame_parser_defines.svh
// Assertion helpers for the frame parser.
`ifndef SYNC_LENGTH_CHECKSUM_FRAME_PARSER_DEFINES_SVH
`define SYNC_LENGTH_CHECKSUM_FRAME_PARSER_DEFINES_SVH

// Property that must hold on every edge out of reset.
`define SLCFP_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next.
`define SLCFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/slcfp_pkg.sv
package slcfp_pkg;

	localparam int PAYLOAD_MAX = 1024;
	localparam int CNT_W       = 11;
	localparam int POS_W       = 10;
	localparam logic [7:0] SYNC_RESET = 8'h5a;

	typedef enum logic [2:0] {
		ST_NONE = 3'd0,
		ST_DATA = 3'd1,
		ST_GOOD = 3'd2,
		ST_BAD  = 3'd3,
		ST_LONG = 3'd4
	} status_t;

	// contents of the input register
	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
	} stage_t;

endpackage

>>> src/slcfp_ifs.sv
interface slcfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcfp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  data_byte;
	logic [9:0]  position;
	logic [10:0] payload_count;

	modport source (output valid, output status, output data_byte, output position,
		output payload_count, input ready);
	modport sink (input valid, input status, input data_byte, input position,
		input payload_count, output ready);
endinterface

>>> src/slcfp_in_reg.sv
module slcfp_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	slcfp_in_if.sink          rx,
	input  logic              adv,
	output slcfp_pkg::stage_t stg_s1
);

	logic                valid_s1;
	logic [7:0]          byte_s1;

	assign rx.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign stg_s1.valid   = valid_s1;
	assign stg_s1.rx_byte = byte_s1;

endmodule

>>> src/slcfp_fsm.sv
`include "sync_length_checksum_frame_parser_defines.svh"

module slcfp_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sync_we,
	input  logic [7:0]        sync_wdata,
	input  slcfp_pkg::stage_t stg_s1,
	output logic              adv,
	slcfp_out_if.source       res
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HDR,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_PAYLOAD,
		PH_CHECK
	} phase_t;

	localparam int CW = slcfp_pkg::CNT_W;
	localparam int PW = slcfp_pkg::POS_W;

	phase_t                   phase_q, phase_d;
	logic [7:0]               sum_q, sum_d;
	logic [7:0]               len_lo_q, len_lo_d;
	logic [CW-1:0]            plen_q, plen_d;
	logic [CW-1:0]            cnt_q, cnt_d;
	logic [7:0]               sync_q;

	logic                     res_valid_q;
	slcfp_pkg::status_t       status_q, status_d;
	logic [7:0]               data_q, data_d;
	logic [PW-1:0]            pos_q, pos_d;

	logic [7:0]               b;
	logic [7:0]               sum_add;
	logic [15:0]              len_full;
	logic [CW-1:0]            cnt_inc;

	assign adv     = stg_s1.valid && (!res_valid_q || res.ready);
	assign b       = stg_s1.rx_byte;
	assign sum_add = sum_q + b;
	assign len_full = {b, len_lo_q};
	assign cnt_inc = cnt_q + CW'(1);

	always_comb begin
		phase_d  = phase_q;
		sum_d    = sum_q;
		len_lo_d = len_lo_q;
		plen_d   = plen_q;
		cnt_d    = cnt_q;
		status_d = slcfp_pkg::ST_NONE;
		data_d   = '0;
		pos_d    = '0;
		case (phase_q)
			PH_IDLE: begin
				sum_d  = '0;
				plen_d = '0;
				cnt_d  = '0;
				if (b == sync_q) begin
					sum_d   = b;
					phase_d = PH_HDR;
				end
			end
			PH_HDR: begin
				sum_d   = sum_add;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				sum_d    = sum_add;
				len_lo_d = b;
				phase_d  = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				sum_d = sum_add;
				// length counts the checksum byte too
				if (len_full > 16'(slcfp_pkg::PAYLOAD_MAX + 1)) begin
					status_d = slcfp_pkg::ST_LONG;
					phase_d  = PH_IDLE;
				end else if (len_full < 16'd2) begin
					plen_d  = '0;
					phase_d = PH_CHECK;
				end else begin
					plen_d  = CW'(len_full - 16'd1);
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				sum_d    = sum_add;
				status_d = slcfp_pkg::ST_DATA;
				data_d   = b;
				pos_d    = cnt_q[PW-1:0];
				cnt_d    = cnt_inc;
				if (cnt_inc >= plen_q) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				status_d = (b == sum_q) ? slcfp_pkg::ST_GOOD : slcfp_pkg::ST_BAD;
				phase_d  = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			sum_q       <= '0;
			len_lo_q    <= '0;
			plen_q      <= '0;
			cnt_q       <= '0;
			sync_q      <= slcfp_pkg::SYNC_RESET;
			res_valid_q <= 1'b0;
			status_q    <= slcfp_pkg::ST_NONE;
			data_q      <= '0;
			pos_q       <= '0;
		end else begin
			if (sync_we) begin
				sync_q <= sync_wdata;
			end
			if (adv) begin
				phase_q     <= phase_d;
				sum_q       <= sum_d;
				len_lo_q    <= len_lo_d;
				plen_q      <= plen_d;
				cnt_q       <= cnt_d;
				res_valid_q <= 1'b1;
				status_q    <= status_d;
				data_q      <= data_d;
				pos_q       <= pos_d;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid         = res_valid_q;
	assign res.status        = status_q;
	assign res.data_byte     = data_q;
	assign res.position      = pos_q;
	assign res.payload_count = cnt_q;

	`SLCFP_ASSERT(a_cnt_cap, clk, arst_n, cnt_q <= CW'(slcfp_pkg::PAYLOAD_MAX),
		"payload count above capacity")
	`SLCFP_ASSERT(a_cnt_in_frame, clk, arst_n, (phase_q != PH_PAYLOAD) || (cnt_q < plen_q),
		"payload phase past frame length")
	`SLCFP_ASSERT(a_data_zero, clk, arst_n,
		!res_valid_q || (status_q == slcfp_pkg::ST_DATA) || (data_q == '0 && pos_q == '0),
		"data or position set outside a payload transfer")
	`SLCFP_ASSERT_NEXT(a_long_drop, clk, arst_n, adv && status_d == slcfp_pkg::ST_LONG,
		phase_q == PH_IDLE, "oversize frame not dropped")
	`SLCFP_ASSERT_NEXT(a_end_idle, clk, arst_n,
		adv && (status_d == slcfp_pkg::ST_GOOD || status_d == slcfp_pkg::ST_BAD),
		phase_q == PH_IDLE && res_valid_q, "frame end did not return to idle")

endmodule

>>> src/sync_length_checksum_frame_parser.sv
// Throughput: one byte per cycle while results are taken. Each byte passes
// the input register, its result the result register; each holds one item,
// and the result register frees in the cycle it is taken. Reset (arst_n
// low, async): parser idle waiting for sync, sum, length and count cleared,
// no result pending, sync byte back to 0x5A.
module sync_length_checksum_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sync_we,
	input  logic [7:0]  sync_wdata,
	slcfp_in_if.sink    rx,
	slcfp_out_if.source res
);

	slcfp_pkg::stage_t stg_s1;
	logic              adv;

	slcfp_in_reg u_in_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.adv    (adv),
		.stg_s1 (stg_s1)
	);

	slcfp_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.sync_we    (sync_we),
		.sync_wdata (sync_wdata),
		.stg_s1     (stg_s1),
		.adv        (adv),
		.res        (res)
	);

endmodule

>>> bench/tb.sv
module tb;
	import slcfp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BYTES = 120;
	localparam int N_PHASES    = 6;

	// parser phases as seen by the predictor
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HDR,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_PAYLOAD,
		PH_CHECK
	} parse_phase_t;

	typedef struct packed {
		status_t          status;
		logic [7:0]       data_byte;
		logic [POS_W-1:0] position;
		logic [CNT_W-1:0] payload_count;
	} parse_out_t;

	logic       clk;
	logic       arst_n;
	logic       sync_we;
	logic [7:0] sync_wdata;

	slcfp_in_if  rx_if ();
	slcfp_out_if res_if ();

	sync_length_checksum_frame_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sync_we    (sync_we),
		.sync_wdata (sync_wdata),
		.rx         (rx_if),
		.res        (res_if)
	);

	logic [7:0] rx_bytes_q[$];
	parse_out_t parse_out_q[$];

	// predictor state
	parse_phase_t p_phase;
	logic [7:0]   p_sum;
	logic [15:0]  p_len;
	logic [10:0]  p_cnt;
	logic [7:0]   p_sync;

	logic [7:0] sync_cfg;
	int         queued;
	int         burst_left;
	int         gap_left;
	bit         gap_en;
	int         stall_mode;
	int         cycles;
	int         errors;
	int         n_bytes, n_data, n_good, n_bad, n_long;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				parse_out_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic parse_out_t parse_byte(input logic [7:0] b);
		parse_out_t r;
		int         plen;
		r = '0;
		r.status = ST_NONE;
		case (p_phase)
			PH_IDLE: begin
				p_sum = '0;
				p_len = '0;
				p_cnt = '0;
				if (b == p_sync) begin
					p_sum = b;
					p_phase = PH_HDR;
				end
			end
			PH_HDR: begin
				p_sum += b;
				p_phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				p_sum += b;
				p_len = {8'h00, b};
				p_phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				p_sum += b;
				p_len = {b, p_len[7:0]};
				plen = (p_len >= 2) ? p_len - 1 : 0;
				if (plen > PAYLOAD_MAX) begin
					r.status = ST_LONG;
					p_phase = PH_IDLE;
				end else if (plen == 0) begin
					p_phase = PH_CHECK;
				end else begin
					p_phase = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				p_sum += b;
				r.status = ST_DATA;
				r.data_byte = b;
				r.position = p_cnt[POS_W-1:0];
				p_cnt++;
				plen = (p_len >= 2) ? p_len - 1 : 0;
				if (p_cnt >= plen)
					p_phase = PH_CHECK;
			end
			PH_CHECK: begin
				r.status = (b == p_sum) ? ST_GOOD : ST_BAD;
				p_phase = PH_IDLE;
			end
			default: p_phase = PH_IDLE;
		endcase
		r.payload_count = p_cnt;
		return r;
	endfunction

	// driver: bursts of transfers separated by random gaps when gaps are enabled
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_if.valid <= 1'b0;
			rx_if.rx_byte <= 8'h00;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (rx_if.valid && rx_if.ready) begin
				parse_out_q.push_back(parse_byte(rx_if.rx_byte));
				void'(rx_bytes_q.pop_front());
				n_bytes++;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 32);
					gap_left = gap_en ? $urandom_range(1, 6) : 0;
				end
			end
			// a byte not yet taken stays on the bus
			if (!rx_if.valid || rx_if.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					rx_if.valid <= 1'b0;
				end else if (rx_bytes_q.size() > 0) begin
					rx_if.valid <= 1'b1;
					rx_if.rx_byte <= rx_bytes_q[0];
				end else begin
					rx_if.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: result checking plus receiver back-pressure
	always @(posedge clk) begin
		parse_out_t got;
		parse_out_t want;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				got.status = status_t'(res_if.status);
				got.data_byte = res_if.data_byte;
				got.position = res_if.position;
				got.payload_count = res_if.payload_count;
				if (parse_out_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: status %0d data %02h pos %0d count %0d",
							res_if.status, got.data_byte, got.position, got.payload_count);
				end else begin
					want = parse_out_q.pop_front();
					case (want.status)
						ST_DATA: n_data++;
						ST_GOOD: n_good++;
						ST_BAD:  n_bad++;
						ST_LONG: n_long++;
						default: ;
					endcase
					if (res_if.status !== want.status || got.data_byte !== want.data_byte ||
							got.position !== want.position ||
							got.payload_count !== want.payload_count) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch at cycle %0d: expected status %0d data %02h",
								cycles, want.status, want.data_byte);
							$display("  pos %0d count %0d, got status %0d data %02h",
								want.position, want.payload_count, res_if.status,
								got.data_byte);
							$display("  pos %0d count %0d", got.position,
								got.payload_count);
						end
					end
				end
			end
			case (stall_mode)
				0:       res_if.ready <= 1'b1;
				1:       res_if.ready <= ($urandom_range(0, 9) >= 3);
				2:       res_if.ready <= ((cycles % 7) >= 2);
				default: res_if.ready <= ((cycles % 64) < 40);
			endcase
		end
	end

	task automatic push_byte(input logic [7:0] b);
		rx_bytes_q.push_back(b);
		queued++;
	endtask

	// keep < 0 sends the whole frame, otherwise only its first keep bytes
	task automatic add_frame(input int len_field, input bit bad_sum, input int keep);
		logic [7:0] f[$];
		logic [7:0] sum;
		int         n;
		f.push_back(sync_cfg);
		f.push_back(8'($urandom));
		f.push_back(len_field[7:0]);
		f.push_back(len_field[15:8]);
		n = (len_field >= 2) ? len_field - 1 : 0;
		if (n <= PAYLOAD_MAX) begin
			repeat (n) f.push_back(8'($urandom));
			sum = '0;
			foreach (f[k]) sum += f[k];
			f.push_back(bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
		end
		if (keep < 0 || keep > f.size())
			keep = f.size();
		for (int k = 0; k < keep; k++)
			push_byte(f[k]);
	endtask

	task automatic write_sync(input logic [7:0] v);
		@(posedge clk);
		sync_we <= 1'b1;
		sync_wdata <= v;
		@(posedge clk);
		sync_we <= 1'b0;
		p_sync = v;
		sync_cfg = v;
	endtask

	task automatic drain();
		while (rx_bytes_q.size() != 0 || parse_out_q.size() != 0 || rx_if.valid)
			@(posedge clk);
	endtask

	task automatic random_phase(input int budget, input bit with_max);
		int start;
		int pick;
		int len;
		if (with_max)
			add_frame(PAYLOAD_MAX + 1, 1'b0, -1);
		start = queued;
		while (queued - start < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 78) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 22);
				if ($urandom_range(0, 59) == 0)
					len = $urandom_range(200, 300);
				add_frame(len, $urandom_range(0, 3) == 0, -1);
			end else if (pick < 86) begin
				repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
			end else if (pick < 93) begin
				// frame cut short; what follows lands in the wrong fields
				add_frame($urandom_range(2, 22), 1'b0, $urandom_range(1, 5));
			end else if (pick < 97) begin
				add_frame($urandom_range(PAYLOAD_MAX + 2, 65535), 1'b0, -1);
			end else begin
				add_frame(PAYLOAD_MAX + 2, 1'b0, -1);
			end
		end
	endtask

	initial begin
		logic [7:0] sv_sync;
		arst_n = 1'b0;
		sync_we = 1'b0;
		sync_wdata = 8'h00;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = 8'h00;
		res_if.ready = 1'b0;
		p_phase = PH_IDLE;
		p_sum = '0;
		p_len = '0;
		p_cnt = '0;
		p_sync = SYNC_RESET;
		sync_cfg = SYNC_RESET;
		gap_en = 1'b0;
		stall_mode = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: ignored bytes, short lengths, bad sum, oversize frames
		write_sync(SYNC_RESET);
		push_byte(8'h00);
		push_byte(8'hff);
		add_frame(0, 1'b0, -1);
		add_frame(1, 1'b1, -1);
		add_frame(3, 1'b0, -1);
		add_frame(PAYLOAD_MAX + 2, 1'b0, -1);
		add_frame(16'hffff, 1'b0, -1);
		drain();

		// sender holds off between settings until all results are in
		for (int i = 0; i < N_PHASES; i++) begin
			case (i)
				0:       sv_sync = 8'h00;
				1:       sv_sync = 8'hff;
				3:       sv_sync = SYNC_RESET;
				default: sv_sync = 8'($urandom);
			endcase
			write_sync(sv_sync);
			stall_mode = i % 4;
			gap_en = (i % 3) != 0;
			random_phase(PHASE_BYTES, i == 2);
			drain();
		end
		repeat (10) @(posedge clk);

		$display("%0d bytes sent over %0d sync settings with mixed bursts and stalls;",
			n_bytes, N_PHASES + 1);
		$display("%0d payload bytes, %0d good frames, %0d bad checksums, %0d oversize frames",
			n_data, n_good, n_bad, n_long);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", errors);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
